@@ src/aktrg_pkg.sv @@
// Package for the AES-keyed tree random generator.
// Payload structs, opcodes, controller/datapath command types and AES helpers.
package aktrg_pkg;

    localparam int KeyWidth  = 128;
    localparam int WordWidth = 64;

    typedef enum logic [1:0] {
        FUNC_ROOT    = 2'd0,
        FUNC_DESCEND = 2'd1,
        FUNC_VALUE   = 2'd2,
        FUNC_BOUNDED = 2'd3
    } func_t;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [63:0] index;
        logic signed [63:0] range_low;
        logic signed [63:0] range_high;
    } in_item_t;

    typedef struct packed {
        logic [63:0] value;
        logic [63:0] node_id;
        logic        range_error;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture input item
        logic aes_start;  // start encryption
        logic aes_idx;    // 1: plaintext is index, 0: plaintext is zero
        logic save_e0;    // keep E(0) result
        logic mod_start;  // start modulo
        logic do_root;
        logic do_descend;
        logic set_value;  // value <= low(E(index))
        logic set_bound;  // value <= remainder + low
        logic set_err;    // value <= low, error flag
        logic clr_value;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic aes_done;
        logic mod_done;
        logic range_zero;
        logic [1:0] func;
    } dp_status_t;

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[x];
    endfunction

endpackage

@@ src/aktrg_aes.sv @@
// Iterative AES-128 encryption core: one round per cycle, round key on the fly.
// Depends on aktrg_pkg (sbox, xtime). Byte i of key/block sits at bits [8i+7:8i].
module aktrg_aes
    import aktrg_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [127:0] key,
    input  logic [127:0] din,
    output logic         done,
    output logic [127:0] dout
);
    logic [127:0] state_reg, state_next;
    logic [127:0] rk_reg, rk_next;
    logic [7:0]   rc_reg, rc_next;
    logic [3:0]   round_reg, round_next;
    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic [127:0] sr, mc, rk_new;
    logic [31:0]  w;

    // next round key from the current one
    always_comb
    begin
        w = {sbox(rk_reg[103:96]), sbox(rk_reg[127:120]),
             sbox(rk_reg[119:112]), sbox(rk_reg[111:104] ^ 8'h00)};
        w[7:0] = sbox(rk_reg[111:104]) ^ rc_reg;
        rk_new[31:0]   = rk_reg[31:0]   ^ w;
        rk_new[63:32]  = rk_reg[63:32]  ^ rk_new[31:0];
        rk_new[95:64]  = rk_reg[95:64]  ^ rk_new[63:32];
        rk_new[127:96] = rk_reg[127:96] ^ rk_new[95:64];
    end

    // SubBytes + ShiftRows, then MixColumns
    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                sr[8*(j+4*c) +: 8] = sbox(state_reg[8*(j+4*((c+j)&3)) +: 8]);
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            logic [7:0] a0, a1, a2, a3;
            a0 = sr[32*c +: 8];
            a1 = sr[32*c+8 +: 8];
            a2 = sr[32*c+16 +: 8];
            a3 = sr[32*c+24 +: 8];
            mc[32*c +: 8]    = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
            mc[32*c+8 +: 8]  = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
            mc[32*c+16 +: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
            mc[32*c+24 +: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
        end
    end

    // round sequencing
    always_comb
    begin
        state_next = state_reg;
        rk_next    = rk_reg;
        rc_next    = rc_reg;
        round_next = round_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            state_next = din ^ key;
            rk_next    = key;
            rc_next    = 8'h01;
            round_next = 4'd1;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            state_next = ((round_reg == 4'd10) ? sr : mc) ^ rk_new;
            rk_next    = rk_new;
            rc_next    = xtime(rc_reg);
            round_next = round_reg + 4'd1;
            if (round_reg == 4'd10)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            round_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            round_reg <= round_next;
        end
    end

    always_ff @(posedge clk)
    begin
        state_reg <= state_next;
        rk_reg    <= rk_next;
        rc_reg    <= rc_next;
    end

    assign done = done_reg;
    assign dout = state_reg;
endmodule

@@ src/aktrg_mod.sv @@
// Bit-serial 64-bit unsigned remainder: one quotient bit per cycle.
// Depends on aktrg_pkg for the word width.
module aktrg_mod
    import aktrg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [WordWidth-1:0] dividend,
    input  logic [WordWidth-1:0] divisor,
    output logic                 done,
    output logic [WordWidth-1:0] remainder
);
    logic [WordWidth-1:0] rem_reg, rem_next, num_reg, num_next, den_reg;
    logic [WordWidth:0]   trial;
    logic [6:0]           cnt_reg, cnt_next;
    logic                 busy_reg, busy_next, done_reg, done_next;

    always_comb
    begin
        trial     = {rem_reg, num_reg[WordWidth-1]};
        rem_next  = rem_reg;
        num_next  = num_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            num_next  = dividend;
            cnt_next  = 7'(WordWidth);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift in one bit, subtract if it fits
            if (trial >= {1'b0, den_reg})
                rem_next = WordWidth'(trial - {1'b0, den_reg});
            else
                rem_next = trial[WordWidth-1:0];
            num_next = {num_reg[WordWidth-2:0], 1'b0};
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        num_reg <= num_next;
        if (start)
            den_reg <= divisor;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;
endmodule

@@ src/aktrg_datapath.sv @@
// Datapath: node key/id, captured item, AES core, remainder unit, result word.
// Depends on aktrg_pkg, aktrg_aes and aktrg_mod.
module aktrg_datapath
    import aktrg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  dp_cmd_t              cmd,
    input  in_item_t             item,
    input  logic [WordWidth-1:0] root_seed,
    output dp_status_t           status,
    output out_item_t            result
);
    logic [KeyWidth-1:0]  key_reg;
    logic [WordWidth-1:0] id_reg, idx_reg, lo_reg, hi_reg, e0_reg, value_reg;
    logic [1:0]           func_reg;
    logic                 err_reg;
    logic [KeyWidth-1:0]  aes_out;
    logic                 aes_done, mod_done;
    logic [WordWidth-1:0] range, rem;

    assign range = hi_reg - lo_reg;

    aktrg_aes u_aes (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.aes_start),
        .key   (key_reg),
        .din   ({64'd0, cmd.aes_idx ? idx_reg : 64'd0}),
        .done  (aes_done),
        .dout  (aes_out)
    );

    aktrg_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.mod_start),
        .dividend  (e0_reg),
        .divisor   (range),
        .done      (mod_done),
        .remainder (rem)
    );

    // node state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
            id_reg  <= '0;
        end
        else if (cmd.do_root)
        begin
            key_reg <= {64'd0, root_seed};
            id_reg  <= '0;
        end
        else if (cmd.do_descend)
        begin
            key_reg <= aes_out;
            id_reg  <= e0_reg ^ idx_reg;
        end
    end

    // item capture and result word
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= item.func;
            idx_reg  <= item.index;
            lo_reg   <= item.range_low;
            hi_reg   <= item.range_high;
        end
        // E(0) kept as low ^ high for descend, low for bounded draw
        if (cmd.save_e0)
            e0_reg <= (func_reg == FUNC_DESCEND) ? aes_out[63:0] ^ aes_out[127:64]
                                                 : aes_out[63:0];
        if (cmd.clr_value)
        begin
            value_reg <= '0;
            err_reg   <= 1'b0;
        end
        else if (cmd.set_value)
        begin
            value_reg <= aes_out[63:0];
            err_reg   <= 1'b0;
        end
        else if (cmd.set_bound)
        begin
            value_reg <= rem + lo_reg;
            err_reg   <= 1'b0;
        end
        else if (cmd.set_err)
        begin
            value_reg <= lo_reg;
            err_reg   <= 1'b1;
        end
    end

    assign status.aes_done   = aes_done;
    assign status.mod_done   = mod_done;
    assign status.range_zero = (range == '0);
    assign status.func       = func_reg;

    assign result.value       = value_reg;
    assign result.node_id     = id_reg;
    assign result.range_error = err_reg;
endmodule

@@ src/aktrg_ctrl.sv @@
// Controller FSM: sequences AES passes and the remainder unit per item.
// Depends on aktrg_pkg for command/status types and opcodes.
module aktrg_ctrl
    import aktrg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  dp_status_t status,
    output dp_cmd_t    cmd,
    output logic       busy,
    output logic       done
);
    typedef enum logic [2:0] {
        S_IDLE, S_DISPATCH, S_E0, S_EIDX, S_MOD, S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg, done_next;
    // one-shot divider kick on entry to S_MOD
    logic   mod_kick_reg;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd        = '0;
        cmd.load   = start && (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                    state_next = S_DISPATCH;
            end
            S_DISPATCH:
            begin
                case (status.func)
                    FUNC_ROOT:
                    begin
                        cmd.do_root   = 1'b1;
                        cmd.clr_value = 1'b1;
                        state_next    = S_FINISH;
                    end
                    FUNC_VALUE:
                    begin
                        cmd.aes_start = 1'b1;
                        cmd.aes_idx   = 1'b1;
                        state_next    = S_EIDX;
                    end
                    FUNC_BOUNDED:
                    begin
                        if (status.range_zero)
                        begin
                            cmd.set_err = 1'b1;
                            state_next  = S_FINISH;
                        end
                        else
                        begin
                            cmd.aes_start = 1'b1;
                            state_next    = S_E0;
                        end
                    end
                    default:
                    begin
                        cmd.aes_start = 1'b1;
                        state_next    = S_E0;
                    end
                endcase
            end
            S_E0:
            begin
                if (status.aes_done)
                begin
                    cmd.save_e0 = 1'b1;
                    if (status.func == FUNC_DESCEND)
                    begin
                        cmd.aes_start = 1'b1;
                        cmd.aes_idx   = 1'b1;
                        state_next    = S_EIDX;
                    end
                    else
                        state_next = S_MOD;
                end
            end
            S_EIDX:
            begin
                if (status.aes_done)
                begin
                    if (status.func == FUNC_DESCEND)
                    begin
                        cmd.do_descend = 1'b1;
                        cmd.clr_value  = 1'b1;
                    end
                    else
                        cmd.set_value = 1'b1;
                    state_next = S_FINISH;
                end
            end
            S_MOD:
            begin
                // first cycle here starts the divider; e0 is already saved
                if (status.mod_done)
                begin
                    cmd.set_bound = 1'b1;
                    state_next    = S_FINISH;
                end
            end
            S_FINISH:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
        // divider start comes from the registered kick
        cmd.mod_start = mod_kick_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            done_reg     <= 1'b0;
            mod_kick_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            done_reg     <= done_next;
            mod_kick_reg <= (state_reg == S_E0) && (state_next == S_MOD);
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

    // result strobe only after a busy period
    assert property (@(posedge clk) disable iff (!rst_n) done |-> $past(busy))
        else $error("done without busy");
    // no new item while busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !cmd.load)
        else $error("load while busy");
    // divider kicked only on entry to modulo state
    assert property (@(posedge clk) disable iff (!rst_n)
        mod_kick_reg |-> (state_reg == S_MOD))
        else $error("divider kick outside modulo state");
endmodule

@@ src/aes_keyed_tree_random_generator.sv @@
// AES-keyed tree random generator, top level.
// Depends on aktrg_pkg, aktrg_ctrl and aktrg_datapath.
//
// Usage: present an item on in_item and raise start while busy is low; the
// item is taken on that edge. One result comes back on out_item with
// out_valid high for exactly one cycle; the receiver cannot stall it.
// root_seed is written through cfg_valid/cfg_ready (always ready) and only
// takes effect at the next return-to-root item.
// The work per item is set by the 10-round iterative AES core (one round per
// cycle) and the 64-step serial remainder unit: return to root uses neither;
// value at index takes one AES pass; descend takes two AES passes; bounded
// integer takes one AES pass plus 64 remainder steps, and neither when the
// range is zero (error result).
// busy drops with out_valid and a new item may start the same cycle; no new
// item is taken while the previous one is still in flight.
// Reset: node key and id clear to zero, root_seed clears to zero.
module aes_keyed_tree_random_generator
    import aktrg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  in_item_t             in_item,
    output logic                 out_valid,
    output out_item_t            out_item,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [WordWidth-1:0] cfg_data
);
    logic [WordWidth-1:0] seed_reg;
    dp_cmd_t    cmd;
    dp_status_t status;
    logic       ctrl_busy, ctrl_done;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seed_reg <= '0;
        else if (cfg_valid && cfg_ready)
            seed_reg <= cfg_data;
    end

    aktrg_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (ctrl_busy),
        .done   (ctrl_done)
    );

    aktrg_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .item      (in_item),
        .root_seed (seed_reg),
        .status    (status),
        .result    (out_item)
    );

    assign busy      = ctrl_busy;
    assign out_valid = ctrl_done;
endmodule
